// ===== rtl/scrc_pkg.sv =====
// shared types and constants of the single-cycle risc core
// no dependencies; compiled first

package scrc_pkg;

  localparam int unsigned XLEN   = 32;
  localparam int unsigned NREG   = 32;
  localparam int unsigned RAW    = 5;
  localparam int unsigned LEN_W  = 6;

  localparam logic [RAW-1:0]  SP_REG   = 5'd29;
  localparam logic [XLEN-1:0] SP_RESET = 32'd32;
  localparam logic [RAW-1:0]  RA_REG   = 5'd31;

  // primary opcodes
  localparam logic [5:0] OP_RTYPE = 6'd0;
  localparam logic [5:0] OP_J     = 6'd2;
  localparam logic [5:0] OP_JAL   = 6'd3;
  localparam logic [5:0] OP_BEQ   = 6'd4;
  localparam logic [5:0] OP_ADDI  = 6'd8;
  localparam logic [5:0] OP_LW    = 6'd35;
  localparam logic [5:0] OP_SW    = 6'd43;

  // r-type function codes
  localparam logic [5:0] FN_JR  = 6'd8;
  localparam logic [5:0] FN_ADD = 6'd32;
  localparam logic [5:0] FN_SUB = 6'd34;
  localparam logic [5:0] FN_AND = 6'd36;
  localparam logic [5:0] FN_OR  = 6'd37;
  localparam logic [5:0] FN_SLT = 6'd42;

  typedef struct packed {
    logic in_ready;
    logic clr_en;
    logic dec_en;
    logic mod_start;
    logic mem_we;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_valid;
    logic exec_item;
    logic mem_op;
    logic mod_done;
    logic out_free;
  } ctrl_status_t;

endpackage

// ===== rtl/scrc_if.sv =====
// valid/ready channel interfaces for input items and result items
// no dependencies

interface scrc_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [4:0]  load_index;
  logic [31:0] load_word;

  modport source (output valid, cmd, load_index, load_word, input ready);
  modport sink   (input valid, cmd, load_index, load_word, output ready);
endinterface

interface scrc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pc_after;
  logic        halted;
  logic        reg_written;
  logic [4:0]  reg_index;
  logic [31:0] reg_value;
  logic        mem_written;
  logic [4:0]  mem_index;
  logic [31:0] mem_value;

  modport source (output valid, pc_after, halted, reg_written, reg_index, reg_value,
                  mem_written, mem_index, mem_value, input ready);
  modport sink   (input valid, pc_after, halted, reg_written, reg_index, reg_value,
                  mem_written, mem_index, mem_value, output ready);
endinterface

// ===== rtl/single_cycle_risc_core.sv =====
// top level of the load/store risc core: sequencer plus datapath
// uses scrc_pkg, scrc_if, scrc_ctrl, scrc_dp
//
//   port         dir   kind          carries
//   in_i         in    valid/ready   cmd, load_index, load_word
//   out_o        out   valid/ready   pc_after, halted, reg/mem write report
//   cfg_we_i     in    write strobe  program_length in cfg_wdata_i
//
// one item at a time; load and halted items go from acceptance straight to commit,
// alu, branch and jump items pass fetch, register read, decode and commit, and lw/sw
// also take the address remainder and a memory step; the remainder is a mask when
// DATA_DEPTH is a power of two, else a three-step reciprocal multiply
// after reset a clearing pass over max(DATA_DEPTH, 32) entries zeroes data store and register
// file, r29 getting the stack top; no item is taken then, program_length writes still are
// the result register frees the input side: a new item is taken while a result waits,
// and an item stalls only at its commit step while the previous result is untaken

module single_cycle_risc_core #(
  parameter int unsigned INSTR_DEPTH = 32,
  parameter int unsigned DATA_DEPTH  = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [scrc_pkg::LEN_W-1:0] cfg_wdata_i,
  scrc_in_if.sink                    in_i,
  scrc_out_if.source                 out_o
);
  import scrc_pkg::*;

  ctrl_cmd_t    ctrl_cmd;
  ctrl_status_t ctrl_status;

  // input ready comes straight from the sequencer idle step
  assign in_i.ready = ctrl_cmd.in_ready;

  scrc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (ctrl_status),
    .cmd_o    (ctrl_cmd)
  );

  scrc_dp #(
    .INSTR_DEPTH (INSTR_DEPTH),
    .DATA_DEPTH  (DATA_DEPTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_i.valid),
    .in_cmd_i          (in_i.cmd),
    .in_load_index_i   (in_i.load_index),
    .in_load_word_i    (in_i.load_word),
    .out_ready_i       (out_o.ready),
    .out_valid_o       (out_o.valid),
    .out_pc_after_o    (out_o.pc_after),
    .out_halted_o      (out_o.halted),
    .out_reg_written_o (out_o.reg_written),
    .out_reg_index_o   (out_o.reg_index),
    .out_reg_value_o   (out_o.reg_value),
    .out_mem_written_o (out_o.mem_written),
    .out_mem_index_o   (out_o.mem_index),
    .out_mem_value_o   (out_o.mem_value),
    .cmd_i             (ctrl_cmd),
    .status_o          (ctrl_status)
  );

endmodule

// ===== rtl/scrc_mod.sv =====
// remainder of a 32-bit value by a constant divisor
// power-of-two divisors take a mask, others an exact reciprocal multiply in multiply,
// scale-back and subtract steps; uses scrc_pkg

module scrc_mod #(
  parameter int unsigned DIVISOR = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [scrc_pkg::XLEN-1:0]  value_i,
  output logic                       done_o,
  output logic [$clog2(DIVISOR)-1:0] rem_o
);
  import scrc_pkg::*;

  localparam int unsigned RW = $clog2(DIVISOR);

  if ((DIVISOR & (DIVISOR - 1)) == 0) begin : g_mask
    logic          done_q;
    logic [RW-1:0] rem_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
      end else begin
        done_q <= start_i;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        rem_q <= value_i[RW-1:0];
      end
    end

    assign done_o = done_q;
    assign rem_o  = rem_q;
  end else begin : g_recip
    // quotient = (x * M) >> (XLEN + RW) with M = ceil(2^(XLEN+RW) / DIVISOR)
    // is exact for every 32-bit x; remainder = x - quotient * DIVISOR
    localparam logic [63:0]   SCALE  = 64'd1 << (XLEN + RW);
    localparam logic [63:0]   M_FULL = (SCALE + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [XLEN:0] M_C    = M_FULL[XLEN:0];
    localparam int unsigned   PW     = 2 * XLEN + 1;

    logic            mul_q;
    logic            qd_en_q;
    logic            sub_q;
    logic            done_q;
    logic [XLEN-1:0] val_q;
    logic [XLEN-1:0] quo_q;
    logic [XLEN-1:0] qd_q;
    logic [RW-1:0]   rem_q;
    logic [PW-1:0]   prod;
    logic [XLEN-1:0] diff;

    always_comb begin
      prod = PW'(val_q) * PW'(M_C);
      diff = val_q - qd_q;
    end

    // stage valids: multiply, scale back, subtract
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mul_q   <= 1'b0;
        qd_en_q <= 1'b0;
        sub_q   <= 1'b0;
        done_q  <= 1'b0;
      end else begin
        mul_q   <= start_i;
        qd_en_q <= mul_q;
        sub_q   <= qd_en_q;
        done_q  <= sub_q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        val_q <= value_i;
      end
      if (mul_q) begin
        quo_q <= XLEN'(prod >> (XLEN + RW));
      end
      if (qd_en_q) begin
        qd_q <= quo_q * XLEN'(DIVISOR);
      end
      if (sub_q) begin
        rem_q <= diff[RW-1:0];
      end
    end

    assign done_o = done_q;
    assign rem_o  = rem_q;
  end

endmodule

// ===== rtl/scrc_ctrl.sv =====
// sequencer of the core: clearing pass, item acceptance and instruction steps
// uses scrc_pkg command and status structs

module scrc_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  scrc_pkg::ctrl_status_t status_i,
  output scrc_pkg::ctrl_cmd_t    cmd_o
);
  import scrc_pkg::*;

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_FETCH  = 7'b0000100,
    ST_DECODE = 7'b0001000,
    ST_ADDR   = 7'b0010000,
    ST_MEM    = 7'b0100000,
    ST_COMMIT = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (status_i.in_valid) begin
          state_d = status_i.exec_item ? ST_FETCH : ST_COMMIT;
        end
      end
      ST_FETCH: begin
        state_d = ST_DECODE;
      end
      ST_DECODE: begin
        cmd_o.dec_en = 1'b1;
        if (status_i.mem_op) begin
          cmd_o.mod_start = 1'b1;
          state_d         = ST_ADDR;
        end else begin
          state_d = ST_COMMIT;
        end
      end
      ST_ADDR: begin
        if (status_i.mod_done) begin
          state_d = ST_MEM;
        end
      end
      ST_MEM: begin
        cmd_o.mem_we = 1'b1;
        state_d      = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/scrc_dp.sv =====
// datapath of the core: stores, register file, decode, alu and result register
// uses scrc_pkg and scrc_mod

module scrc_dp #(
  parameter int unsigned INSTR_DEPTH = 32,
  parameter int unsigned DATA_DEPTH  = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [scrc_pkg::LEN_W-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  input  logic                           in_cmd_i,
  input  logic [scrc_pkg::RAW-1:0]       in_load_index_i,
  input  logic [scrc_pkg::XLEN-1:0]      in_load_word_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [scrc_pkg::XLEN-1:0]      out_pc_after_o,
  output logic                           out_halted_o,
  output logic                           out_reg_written_o,
  output logic [scrc_pkg::RAW-1:0]       out_reg_index_o,
  output logic [scrc_pkg::XLEN-1:0]      out_reg_value_o,
  output logic                           out_mem_written_o,
  output logic [scrc_pkg::RAW-1:0]       out_mem_index_o,
  output logic [scrc_pkg::XLEN-1:0]      out_mem_value_o,
  input  scrc_pkg::ctrl_cmd_t            cmd_i,
  output scrc_pkg::ctrl_status_t         status_o
);
  import scrc_pkg::*;

  localparam int unsigned IAW       = $clog2(INSTR_DEPTH);
  localparam int unsigned DAW       = $clog2(DATA_DEPTH);
  localparam int unsigned CLR_DEPTH = (DATA_DEPTH > NREG) ? DATA_DEPTH : NREG;
  localparam int unsigned CW        = $clog2(CLR_DEPTH);
  localparam int unsigned MAP_N     = 2 ** LEN_W;

  // word index to instruction slot, folded at elaboration
  logic [IAW-1:0] slot_map [MAP_N];
  for (genvar g = 0; g < MAP_N; g++) begin : g_slot_map
    localparam int unsigned SLOT = g % INSTR_DEPTH;
    assign slot_map[g] = IAW'(SLOT);
  end

  logic [XLEN-1:0]  imem [INSTR_DEPTH];
  logic [XLEN-1:0]  rf   [NREG];
  logic [XLEN-1:0]  dmem [DATA_DEPTH];

  logic [LEN_W-1:0] len_q;
  logic [XLEN-1:0]  pc_q;
  logic [XLEN-1:0]  pc_inc_q;
  logic             is_load_q;
  logic             halt_q;
  logic [CW-1:0]    clr_cnt_q;
  logic [XLEN-1:0]  instr_q;
  logic [XLEN-1:0]  ra_q;
  logic [XLEN-1:0]  rb_q;
  logic [XLEN-1:0]  dmem_rd_q;

  logic             wr_q;
  logic [RAW-1:0]   widx_q;
  logic [XLEN-1:0]  wval_q;
  logic [XLEN-1:0]  next_q;
  logic             lw_q;
  logic             sw_q;
  logic [XLEN-1:0]  sdata_q;

  logic             out_valid_q;
  logic [XLEN-1:0]  out_pc_q;
  logic             out_halted_q;
  logic             out_rw_q;
  logic [RAW-1:0]   out_ridx_q;
  logic [XLEN-1:0]  out_rval_q;
  logic             out_mw_q;
  logic [RAW-1:0]   out_midx_q;
  logic [XLEN-1:0]  out_mval_q;

  logic             accept;
  logic             load_acc;
  logic             halt_now;
  logic             exec_q;
  logic             clr_in_rf;
  logic             clr_in_dm;
  logic             mod_done;
  logic [DAW-1:0]   didx;

  logic [5:0]       op;
  logic [5:0]       fn;
  logic [RAW-1:0]   rs;
  logic [RAW-1:0]   rt;
  logic [RAW-1:0]   rd;
  logic [XLEN-1:0]  imm;
  logic [XLEN-1:0]  addr_sum;
  logic             dec_wr;
  logic [RAW-1:0]   dec_widx;
  logic [XLEN-1:0]  dec_wval;
  logic [XLEN-1:0]  dec_next;
  logic             dec_lw;
  logic             dec_sw;

  logic             rf_we;
  logic [RAW-1:0]   rf_waddr;
  logic [XLEN-1:0]  rf_wdata;
  logic             dm_we;
  logic [DAW-1:0]   dm_waddr;
  logic [XLEN-1:0]  dm_wdata;
  logic [XLEN-1:0]  ld_value;

  assign accept    = cmd_i.in_ready & in_valid_i;
  assign load_acc  = accept & ~in_cmd_i;
  assign halt_now  = pc_q >= XLEN'(len_q);
  assign exec_q    = ~is_load_q & ~halt_q;
  assign clr_in_rf = {1'b0, clr_cnt_q} < (CW+1)'(NREG);
  assign clr_in_dm = {1'b0, clr_cnt_q} < (CW+1)'(DATA_DEPTH);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      pc_q        <= '0;
      is_load_q   <= 1'b0;
      halt_q      <= 1'b0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
      if (accept) begin
        is_load_q <= ~in_cmd_i;
        halt_q    <= in_cmd_i & halt_now;
      end
      if (cmd_i.clr_en) begin
        clr_cnt_q <= clr_cnt_q + CW'(1);
      end
      if (cmd_i.commit && exec_q) begin
        pc_q <= next_q;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pc_inc_q <= pc_q + XLEN'(1);
  end

  // instruction store, read continuously at the pc's slot, also past the program length
  always_ff @(posedge clk_i) begin
    if (load_acc) begin
      imem[slot_map[LEN_W'(in_load_index_i)]] <= in_load_word_i;
    end
    instr_q <= imem[slot_map[pc_q[LEN_W-1:0]]];
  end

  // decode and execute
  always_comb begin
    op       = instr_q[31:26];
    rs       = instr_q[25:21];
    rt       = instr_q[20:16];
    rd       = instr_q[15:11];
    fn       = instr_q[5:0];
    imm      = {{(XLEN-16){instr_q[15]}}, instr_q[15:0]};
    addr_sum = ra_q + imm;
    dec_wr   = 1'b0;
    dec_widx = rd;
    dec_wval = '0;
    dec_next = pc_inc_q;
    dec_lw   = 1'b0;
    dec_sw   = 1'b0;
    case (op)
      OP_RTYPE: begin
        dec_wr = 1'b1;
        case (fn)
          FN_ADD: dec_wval = ra_q + rb_q;
          FN_SUB: dec_wval = ra_q - rb_q;
          FN_AND: dec_wval = ra_q & rb_q;
          FN_OR:  dec_wval = ra_q | rb_q;
          FN_SLT: dec_wval = XLEN'($signed(ra_q) < $signed(rb_q));
          FN_JR: begin
            dec_wr   = 1'b0;
            dec_next = ra_q;
          end
          default: dec_wr = 1'b0;
        endcase
      end
      OP_LW: begin
        dec_lw   = 1'b1;
        dec_wr   = 1'b1;
        dec_widx = rt;
      end
      OP_SW: begin
        dec_sw = 1'b1;
      end
      OP_BEQ: begin
        if (ra_q == rb_q) begin
          dec_next = pc_inc_q + imm;
        end
      end
      OP_ADDI: begin
        dec_wr   = 1'b1;
        dec_widx = rt;
        dec_wval = addr_sum;
      end
      OP_J: begin
        dec_next = {6'b0, instr_q[25:0]};
      end
      OP_JAL: begin
        dec_wr   = 1'b1;
        dec_widx = RA_REG;
        dec_wval = pc_inc_q;
        dec_next = {6'b0, instr_q[25:0]};
      end
      default: begin
        dec_wr = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.dec_en) begin
      wr_q    <= dec_wr & (dec_widx != '0);
      widx_q  <= dec_widx;
      wval_q  <= dec_wval;
      next_q  <= dec_next;
      lw_q    <= dec_lw;
      sw_q    <= dec_sw;
      sdata_q <= rb_q;
    end
  end

  // register file: clearing pass writes zero, r29 gets the stack top
  assign ld_value = lw_q ? dmem_rd_q : wval_q;
  assign rf_we    = (cmd_i.clr_en & clr_in_rf) | (cmd_i.commit & exec_q & wr_q);
  assign rf_waddr = cmd_i.clr_en ? clr_cnt_q[RAW-1:0] : widx_q;
  assign rf_wdata = cmd_i.clr_en ? ((clr_cnt_q[RAW-1:0] == SP_REG) ? SP_RESET : '0) : ld_value;

  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf[rf_waddr] <= rf_wdata;
    end
    ra_q <= rf[instr_q[25:21]];
    rb_q <= rf[instr_q[20:16]];
  end

  scrc_mod #(
    .DIVISOR (DATA_DEPTH)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mod_start),
    .value_i (addr_sum),
    .done_o  (mod_done),
    .rem_o   (didx)
  );

  // data store
  assign dm_we    = (cmd_i.clr_en & clr_in_dm) | (cmd_i.mem_we & sw_q);
  assign dm_waddr = cmd_i.clr_en ? clr_cnt_q[DAW-1:0] : didx;
  assign dm_wdata = cmd_i.clr_en ? '0 : sdata_q;

  always_ff @(posedge clk_i) begin
    if (dm_we) begin
      dmem[dm_waddr] <= dm_wdata;
    end
    dmem_rd_q <= dmem[didx];
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_pc_q     <= exec_q ? next_q : pc_q;
      out_halted_q <= halt_q;
      out_rw_q     <= exec_q & wr_q;
      out_ridx_q   <= (exec_q & wr_q) ? widx_q : '0;
      out_rval_q   <= (exec_q & wr_q) ? ld_value : '0;
      out_mw_q     <= exec_q & sw_q;
      out_midx_q   <= (exec_q & (lw_q | sw_q)) ? RAW'(didx) : '0;
      out_mval_q   <= (exec_q & sw_q) ? sdata_q :
                      (exec_q & lw_q) ? dmem_rd_q : '0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_pc_after_o    = out_pc_q;
  assign out_halted_o      = out_halted_q;
  assign out_reg_written_o = out_rw_q;
  assign out_reg_index_o   = out_ridx_q;
  assign out_reg_value_o   = out_rval_q;
  assign out_mem_written_o = out_mw_q;
  assign out_mem_index_o   = out_midx_q;
  assign out_mem_value_o   = out_mval_q;

  always_comb begin
    status_o           = '0;
    status_o.clr_last  = clr_cnt_q == CW'(CLR_DEPTH - 1);
    status_o.in_valid  = in_valid_i;
    status_o.exec_item = in_cmd_i & ~halt_now;
    status_o.mem_op    = dec_lw | dec_sw;
    status_o.mod_done  = mod_done;
    status_o.out_free  = ~out_valid_q | out_ready_i;
  end

endmodule

// ===== rtl/scrc_checker.sv =====
// port-level checks of the core and their bind to the top level
// uses scrc_pkg widths

module scrc_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic                      out_halted_i,
  input logic                      out_reg_written_i,
  input logic [scrc_pkg::RAW-1:0]  out_reg_index_i,
  input logic [scrc_pkg::XLEN-1:0] out_reg_value_i,
  input logic                      out_mem_written_i
);
  import scrc_pkg::*;

  // a result waiting to be taken stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before transfer");

  // one item in flight: ready drops right after an input transfer
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while an item is in flight");

  // a halted item changes nothing
  a_halt_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_halted_i |-> !out_reg_written_i && !out_mem_written_i)
    else $error("halted item reports a write");

  // register zero is never reported as written
  a_no_r0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_reg_written_i |-> out_reg_index_i != '0)
    else $error("write to register zero reported");

  // without a register write the write fields read zero
  a_rw_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_reg_written_i |-> out_reg_index_i == '0 && out_reg_value_i == '0)
    else $error("stale register write fields");

endmodule

bind single_cycle_risc_core scrc_checker u_scrc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_halted_i      (out_o.halted),
  .out_reg_written_i (out_o.reg_written),
  .out_reg_index_i   (out_o.reg_index),
  .out_reg_value_i   (out_o.reg_value),
  .out_mem_written_i (out_o.mem_written)
);

// ===== sim/single_cycle_risc_core_chk.sv =====
// result checker for the single-cycle risc core: tracks the architectural state
// of the core from the accepted transfers and compares every result
// depends on scrc_pkg and scrc_if; compiled before single_cycle_risc_core_tb
`timescale 1ns / 100ps

package scrc_tb_pkg;

  typedef enum logic {
    ITEM_LOAD = 1'b0,
    ITEM_EXEC = 1'b1
  } item_kind_e;

  typedef struct packed {
    logic [31:0] pc_after;
    logic        halted;
    logic        reg_written;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        mem_written;
    logic [4:0]  mem_index;
    logic [31:0] mem_value;
  } retire_t;

endpackage

module single_cycle_risc_core_chk
  import scrc_pkg::*;
  import scrc_tb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LEN_W-1:0] cfg_wdata_i,
  scrc_in_if               in_mon,
  scrc_out_if              out_mon,
  output int               mismatches_o,
  output int               pending_o
);

  // architectural state as the core should hold it
  logic [31:0]      pc_m;
  logic [LEN_W-1:0] plen_m;
  logic [31:0]      imem_m [32];
  logic [31:0]      dmem_m [32];
  logic [31:0]      gpr_m  [NREG];

  retire_t retire_q [$];

  initial begin
    mismatches_o = 0;
    pending_o    = 0;
  end

  function automatic retire_t predict_retire(input item_kind_e kind, input logic [4:0] slot,
                                             input logic [31:0] word);
    retire_t     r;
    logic [31:0] ins, a, b, imm, nxt, wval, addr;
    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, widx;
    logic        wr;
    r = '0;
    if (kind == ITEM_LOAD) begin
      imem_m[slot] = word;
      r.pc_after = pc_m;
      return r;
    end
    if (pc_m >= {26'd0, plen_m}) begin
      r.pc_after = pc_m;
      r.halted   = 1'b1;
      return r;
    end
    ins  = imem_m[pc_m[4:0]];
    op   = ins[31:26];
    rs   = ins[25:21];
    rt   = ins[20:16];
    rd   = ins[15:11];
    fn   = ins[5:0];
    imm  = {{16{ins[15]}}, ins[15:0]};
    a    = gpr_m[rs];
    b    = gpr_m[rt];
    nxt  = pc_m + 32'd1;
    wr   = 1'b0;
    widx = '0;
    wval = '0;
    case (op)
      OP_RTYPE: begin
        wr   = 1'b1;
        widx = rd;
        case (fn)
          FN_ADD: wval = a + b;
          FN_SUB: wval = a - b;
          FN_AND: wval = a & b;
          FN_OR:  wval = a | b;
          FN_SLT: wval = {31'd0, $signed(a) < $signed(b)};
          FN_JR: begin
            wr  = 1'b0;
            nxt = a;
          end
          default: wr = 1'b0;
        endcase
      end
      OP_LW: begin
        addr        = a + imm;
        wr          = 1'b1;
        widx        = rt;
        wval        = dmem_m[addr[4:0]];
        r.mem_index = addr[4:0];
        r.mem_value = wval;
      end
      OP_SW: begin
        addr                = a + imm;
        dmem_m[addr[4:0]]   = b;
        r.mem_written       = 1'b1;
        r.mem_index         = addr[4:0];
        r.mem_value         = b;
      end
      OP_BEQ: begin
        if (a == b) nxt = nxt + imm;
      end
      OP_ADDI: begin
        wr   = 1'b1;
        widx = rt;
        wval = a + imm;
      end
      OP_J: nxt = {6'd0, ins[25:0]};
      OP_JAL: begin
        wr   = 1'b1;
        widx = RA_REG;
        wval = nxt;
        nxt  = {6'd0, ins[25:0]};
      end
      default: ;
    endcase
    // register 0 swallows the write
    if (wr && widx != '0) begin
      gpr_m[widx]   = wval;
      r.reg_written = 1'b1;
      r.reg_index   = widx;
      r.reg_value   = wval;
    end
    pc_m       = nxt;
    r.pc_after = nxt;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      if (mismatches_o < 10)
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    retire_t want;
    if (!rst_ni) begin
      pc_m   = '0;
      plen_m = '0;
      for (int i = 0; i < 32; i++) begin
        imem_m[i] = '0;
        dmem_m[i] = '0;
        gpr_m[i]  = '0;
      end
      gpr_m[SP_REG] = SP_RESET;
      retire_q.delete();
    end else begin
      if (cfg_we_i) plen_m = cfg_wdata_i;
      if (out_mon.valid && out_mon.ready) begin
        if (retire_q.size() == 0) begin
          if (mismatches_o < 10)
            $display("%0t: result transfer with nothing pending, pc_after %h",
                     $time, out_mon.pc_after);
          mismatches_o++;
        end else begin
          want = retire_q.pop_front();
          check_field("pc_after", want.pc_after, out_mon.pc_after);
          check_field("halted", 32'(want.halted), 32'(out_mon.halted));
          check_field("reg_written", 32'(want.reg_written), 32'(out_mon.reg_written));
          check_field("reg_index", 32'(want.reg_index), 32'(out_mon.reg_index));
          check_field("reg_value", want.reg_value, out_mon.reg_value);
          check_field("mem_written", 32'(want.mem_written), 32'(out_mon.mem_written));
          check_field("mem_index", 32'(want.mem_index), 32'(out_mon.mem_index));
          check_field("mem_value", want.mem_value, out_mon.mem_value);
        end
      end
      if (in_mon.valid && in_mon.ready)
        retire_q.push_back(predict_retire(item_kind_e'(in_mon.cmd), in_mon.load_index,
                                          in_mon.load_word));
    end
    pending_o = retire_q.size();
  end

endmodule

// ===== sim/single_cycle_risc_core_tb.sv =====
// testbench top for single_cycle_risc_core: clock, reset, program loading and
// run requests, random back-pressure, watchdog and the final verdict
// depends on scrc_pkg, scrc_if, the core rtl and single_cycle_risc_core_chk
`timescale 1ns / 100ps

module single_cycle_risc_core_tb;
  import scrc_pkg::*;
  import scrc_tb_pkg::*;

  localparam int ITEMS       = 1300;  // random phases stop once this many items went in
  localparam int HOLD_AT     = 700;   // item count past which the long result stall starts
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 4000;  // cycles with no transfer before giving up
  localparam int DRAIN       = 60;
  localparam int DEMO_LEN    = 17;
  localparam int IDLE_PCT    = 29;

  // function code that the core does not know
  localparam logic [5:0] FN_UNUSED = 6'd63;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [LEN_W-1:0] cfg_wdata;
  int               mismatches;
  int               pending;

  int          n_sent    = 0;  // input transfers
  int          n_done    = 0;  // result transfers
  int          n_phases  = 0;
  int          quiet     = 0;  // cycles since the last transfer
  logic [31:0] last_pc   = '0; // pc_after of the newest result
  bit          hold_req  = 1'b0;
  bit          hold_done = 1'b0;
  logic [31:0] demo_prog [DEMO_LEN];

  scrc_in_if  in_ch ();
  scrc_out_if out_ch ();

  single_cycle_risc_core DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  single_cycle_risc_core_chk u_chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  // 2 ns clock
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // transfer bookkeeping and the watchdog; a stalled core ends the run here
  always @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) n_sent <= n_sent + 1;
    if (out_ch.valid && out_ch.ready) begin
      n_done  <= n_done + 1;
      last_pc <= out_ch.pc_after;
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results still due",
                 STALL_LIMIT, pending);
        $display("single_cycle_risc_core_tb: done, errors");
        $finish;
      end
    end
  end

  // result side: random stalls, a stall-free stretch, and one long hold-off
  // that lets the core fill up while the sender keeps offering items
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (n_done >= 300 && n_done < 500) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  function automatic logic [31:0] enc_r(input logic [5:0] fn, input logic [4:0] rs,
                                        input logic [4:0] rt, input logic [4:0] rd,
                                        input logic [4:0] sh);
    return {OP_RTYPE, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] enc_i(input logic [5:0] op, input logic [4:0] rs,
                                        input logic [4:0] rt, input logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [31:0] enc_j(input logic [5:0] op, input logic [25:0] tgt);
    return {op, tgt};
  endfunction

  // random instruction for slot s; every control transfer lands in 0..31 and
  // register 31 only ever holds a return slot, so pc never leaves the store
  function automatic logic [31:0] gen_instr(input int s);
    int          roll;
    logic [5:0]  fn, op;
    logic [4:0]  rs, rt;
    logic [15:0] off;
    roll = $urandom_range(0, 99);
    rs   = 5'($urandom);
    rt   = 5'($urandom);
    // the last slot must jump, falling through it would strand pc at 32
    if (s == 31) return enc_j(OP_J, 26'($urandom_range(0, 31)));
    if (roll < 30) begin
      case ($urandom_range(0, 4))
        0:       fn = FN_ADD;
        1:       fn = FN_SUB;
        2:       fn = FN_AND;
        3:       fn = FN_OR;
        default: fn = FN_SLT;
      endcase
      return enc_r(fn, rs, rt, 5'($urandom_range(0, 30)), 5'($urandom));
    end
    if (roll < 42) return enc_i(OP_ADDI, rs, 5'($urandom_range(0, 30)), 16'($urandom));
    if (roll < 52) return enc_i(OP_LW, rs, 5'($urandom_range(0, 30)), 16'($urandom));
    if (roll < 62) return enc_i(OP_SW, rs, rt, 16'($urandom));
    if (roll < 74) begin
      // offset chosen so the taken target is a real slot; equal operands half the time
      off = 16'($urandom_range(0, 31) - s - 1);
      if ($urandom_range(0, 1)) rt = rs;
      return enc_i(OP_BEQ, rs, rt, off);
    end
    if (roll < 79) return enc_j(OP_J, 26'($urandom_range(0, 31)));
    if (roll < 84) return enc_j(OP_JAL, 26'($urandom_range(0, 31)));
    if (roll < 89)
      return enc_r(FN_JR, $urandom_range(0, 1) ? RA_REG : 5'd0, rt, 5'($urandom), 5'($urandom));
    if (roll < 94) begin
      do fn = 6'($urandom);
      while (fn == FN_JR || fn == FN_ADD || fn == FN_SUB || fn == FN_AND || fn == FN_OR ||
             fn == FN_SLT);
      return enc_r(fn, rs, rt, 5'($urandom), 5'($urandom));
    end
    do op = 6'($urandom);
    while (op == OP_RTYPE || op == OP_J || op == OP_JAL || op == OP_BEQ || op == OP_ADDI ||
           op == OP_LW || op == OP_SW);
    return {op, 26'($urandom)};
  endfunction

  // one input transfer; entered and left at a falling edge
  task automatic send_item(input item_kind_e kind, input logic [4:0] slot,
                           input logic [31:0] word);
    while (!(n_sent >= 300 && n_sent < 500) && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= kind;
    in_ch.load_index <= slot;
    in_ch.load_word  <= word;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // drop valid and wait for every result to come back
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(negedge clk);
    while (n_done != n_sent);
  endtask

  task automatic write_len(input logic [LEN_W-1:0] len);
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // one program phase: bring pc home if needed, set the length, load the
  // program, then mostly run requests with a sprinkle of reloads
  task automatic run_phase(input int len, input int n_exec, input bit wild);
    logic [4:0] rnd_slot;
    wait_idle();
    if (len > 0 && (wild || last_pc >= len)) begin
      // pc sits past the new program: plant a jump to 0 where it stands
      write_len(last_pc[LEN_W-1:0] + 1'b1);
      send_item(ITEM_LOAD, last_pc[4:0], enc_j(OP_J, 26'd0));
      send_item(ITEM_EXEC, 5'($urandom), $urandom);
      wait_idle();
    end
    write_len(LEN_W'(len));
    for (int s = 0; s < len; s++) begin
      // wild phase: taken branch with the most negative offset throws pc far away
      if (wild && s == 0) send_item(ITEM_LOAD, 5'd0, enc_i(OP_BEQ, 5'd0, 5'd0, 16'h8000));
      else send_item(ITEM_LOAD, 5'(s), gen_instr(s));
    end
    if (!hold_done && n_sent >= HOLD_AT && n_exec >= 20) hold_req = 1'b1;
    for (int i = 0; i < n_exec; i++) begin
      if ($urandom_range(0, 99) < 8) begin
        // reloads: garbage only where the current program cannot fetch it
        rnd_slot = 5'($urandom);
        if (rnd_slot >= len) send_item(ITEM_LOAD, rnd_slot, $urandom);
        else send_item(ITEM_LOAD, rnd_slot, gen_instr(rnd_slot));
      end else begin
        send_item(ITEM_EXEC, 5'($urandom), $urandom);
      end
    end
    n_phases++;
  endtask

  initial begin
    int roll;
    in_ch.valid      = 1'b0;
    in_ch.cmd        = ITEM_LOAD;
    in_ch.load_index = '0;
    in_ch.load_word  = '0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    rst_n            = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed program: sign and wrap corners, every operation, an r0 write,
    // an extreme branch offset not taken, a taken branch, jal/jr round trip
    demo_prog[0]  = enc_i(OP_ADDI, 5'd0, 5'd1, 16'h7FFF);
    demo_prog[1]  = enc_i(OP_ADDI, 5'd0, 5'd2, 16'h8000);
    demo_prog[2]  = enc_r(FN_SUB, 5'd2, 5'd1, 5'd3, 5'd0);
    demo_prog[3]  = enc_r(FN_SLT, 5'd2, 5'd1, 5'd4, 5'd0);  // negative < positive
    demo_prog[4]  = enc_r(FN_AND, 5'd1, 5'd2, 5'd5, 5'd0);
    demo_prog[5]  = enc_r(FN_OR, 5'd1, 5'd2, 5'd6, 5'd0);
    demo_prog[6]  = enc_r(FN_ADD, 5'd6, 5'd6, 5'd7, 5'd0);  // wraps
    demo_prog[7]  = enc_i(OP_SW, SP_REG, 5'd6, 16'h7FFF);   // stack reg + max offset
    demo_prog[8]  = enc_i(OP_LW, 5'd0, 5'd8, 16'hFFFF);     // reads back the store
    demo_prog[9]  = enc_i(OP_BEQ, 5'd1, 5'd2, 16'h8000);
    demo_prog[10] = enc_i(OP_BEQ, 5'd0, 5'd0, 16'h0000);
    demo_prog[11] = 32'hFFFF_FFFF;                           // unknown opcode
    demo_prog[12] = enc_j(OP_JAL, 26'd14);
    demo_prog[13] = enc_j(OP_J, 26'd15);
    demo_prog[14] = enc_r(FN_JR, RA_REG, 5'd0, 5'd0, 5'd0);
    demo_prog[15] = enc_i(OP_ADDI, 5'd1, 5'd0, 16'hFFFF);   // r0 stays zero
    demo_prog[16] = enc_r(FN_UNUSED, 5'd31, 5'd31, 5'd31, 5'd31);

    // length is still 0 after reset, so this run request halts at pc 0
    send_item(ITEM_EXEC, 5'd31, 32'hFFFF_FFFF);
    for (int s = 0; s < DEMO_LEN; s++) send_item(ITEM_LOAD, 5'(s), demo_prog[s]);
    wait_idle();
    write_len(LEN_W'(DEMO_LEN));
    // two extra requests find pc at the end of the program
    for (int i = 0; i < DEMO_LEN + 2; i++) send_item(ITEM_EXEC, 5'($urandom), $urandom);
    n_phases++;

    // random programs, lengths from empty to the whole store
    while (n_sent < ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 5)       run_phase(0, $urandom_range(20, 40), 1'b0);
      else if (roll < 12) run_phase(32, $urandom_range(20, 70), 1'b0);
      else if (roll < 18) run_phase(1, $urandom_range(20, 40), 1'b0);
      else                run_phase($urandom_range(2, 31), $urandom_range(20, 70), 1'b0);
    end
    // last of all, since pc cannot come back from there
    run_phase(2, 6, 1'b1);

    wait_idle();
    repeat (DRAIN) @(posedge clk);
    $display("covered %0d items in %0d program phases, %0d results compared, %0d bad fields",
             n_sent, n_phases, n_done, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("single_cycle_risc_core_tb: done, clean");
    end else begin
      $display("single_cycle_risc_core_tb: done, errors");
    end
    $finish;
  end

endmodule
